// ----- hw/rtl/scc_pkg.sv -----
// Shared widths, types and constants for the segment corner check pipeline.
`timescale 1ns / 1ps

package scc_pkg;

    // Field and datapath widths
    localparam int COORD_W  = 16;              // signed Q12.4 coordinate
    localparam int DIFF_W   = COORD_W + 1;     // difference of two coordinates
    localparam int MAG_W    = COORD_W;         // magnitude of a difference
    localparam int PROD_W   = 2 * COORD_W + 1; // signed product of two differences
    localparam int CROSS_W  = PROD_W + 1;      // difference of two products
    localparam int TOL_W    = 12;              // tolerance register
    localparam int TPROD_W  = TOL_W + MAG_W;   // tolerance times |dx|
    localparam int SQ_W     = 2 * MAG_W;       // square of a difference
    localparam int LEN_W    = SQ_W + 1;        // squared length
    localparam int RATIO_W  = 5;               // room for the ratio factor
    localparam int SCALED_W = LEN_W + RATIO_W; // ratio factor times squared length

    localparam int IN_BYTES  = (10 * COORD_W + 7) / 8;
    localparam int OUT_BYTES = 1;

    // One fifth of the length, squared: 25 * near^2 <= ref^2
    localparam int RATIO_SQ = 25;

    // Three pixels in Q12.4
    localparam logic [TOL_W-1:0] TOL_RESET = 12'd48;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic        [MAG_W-1:0]    mag_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [CROSS_W-1:0]  cross_t;
    typedef logic        [TOL_W-1:0]    tol_t;
    typedef logic        [TPROD_W-1:0]  tprod_t;
    typedef logic        [SQ_W-1:0]     sq_t;
    typedef logic        [LEN_W-1:0]    len_t;
    typedef logic        [SCALED_W-1:0] scaled_t;

endpackage

// ----- hw/rtl/segment_corner_check.sv -----
// Throughput: one item per cycle; a stall on m_tready holds all five stages together.
// The rate is set by the product stage of the containment test, one multiplier deep.
// Reset clears every stage valid bit and the output valid, and loads tolerance with 48.
// No clearing pass: the block takes items from the first cycle after reset.
`timescale 1ns / 1ps

module segment_corner_check
    import scc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // tolerance register write
    input  logic                   cfg_wen,
    input  logic [TOL_W-1:0]       cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // cross_x, cross_y, first_outer_x, first_outer_y, first_inner_x, first_inner_y,
    // second_inner_x, second_inner_y, second_outer_x, second_outer_y (16 bit each)
    input  logic [8*IN_BYTES-1:0]  s_tdata,
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // meets, then zero padding
    output logic [8*OUT_BYTES-1:0] m_tdata
);

    localparam int NSEG   = 2;
    localparam int NSTAGE = 4;

    // Tolerance register
    tol_t tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tolerance_reg <= TOL_RESET;
        else if (cfg_wen)
            tolerance_reg <= cfg_wdata;
    end

    // Pipeline advance: move when the output register is free or being taken
    logic              en;
    logic [NSTAGE-1:0] valid_reg, valid_next;
    logic              m_tvalid_reg, m_tvalid_next;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        valid_next    = {valid_reg[NSTAGE-2:0], s_tvalid};
        m_tvalid_next = valid_reg[NSTAGE-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Unpack the input item
    coord_t cx, cy;
    coord_t o_x [NSEG];
    coord_t o_y [NSEG];
    coord_t i_x [NSEG];
    coord_t i_y [NSEG];

    assign cx     = s_tdata[0*COORD_W +: COORD_W];
    assign cy     = s_tdata[1*COORD_W +: COORD_W];
    assign o_x[0] = s_tdata[2*COORD_W +: COORD_W];
    assign o_y[0] = s_tdata[3*COORD_W +: COORD_W];
    assign i_x[0] = s_tdata[4*COORD_W +: COORD_W];
    assign i_y[0] = s_tdata[5*COORD_W +: COORD_W];
    assign i_x[1] = s_tdata[6*COORD_W +: COORD_W];
    assign i_y[1] = s_tdata[7*COORD_W +: COORD_W];
    assign o_x[1] = s_tdata[8*COORD_W +: COORD_W];
    assign o_y[1] = s_tdata[9*COORD_W +: COORD_W];

    // Per-segment tests and lengths, stages one to four
    logic    cross_in  [NSEG];
    logic    outer_in  [NSEG];
    len_t    l_ic      [NSEG];
    len_t    l_io      [NSEG];
    len_t    l_oc      [NSEG];
    len_t    l_ic4_reg [NSEG];
    len_t    l_io4_reg [NSEG];
    scaled_t s_oc4_reg [NSEG];

    for (genvar k = 0; k < NSEG; k++)
    begin : g_seg
        // crossing point on outer..inner
        scc_contain u_cross_in (
            .clk    (clk),
            .en     (en),
            .tol    (tolerance_reg),
            .px     (cx),
            .py     (cy),
            .ax     (o_x[k]),
            .ay     (o_y[k]),
            .bx     (i_x[k]),
            .by     (i_y[k]),
            .on_seg (cross_in[k])
        );

        // outer end on crossing..inner
        scc_contain u_outer_in (
            .clk    (clk),
            .en     (en),
            .tol    (tolerance_reg),
            .px     (o_x[k]),
            .py     (o_y[k]),
            .ax     (cx),
            .ay     (cy),
            .bx     (i_x[k]),
            .by     (i_y[k]),
            .on_seg (outer_in[k])
        );

        scc_len u_len_ic (
            .clk  (clk),
            .en   (en),
            .ax   (i_x[k]),
            .ay   (i_y[k]),
            .bx   (cx),
            .by   (cy),
            .len2 (l_ic[k])
        );

        scc_len u_len_io (
            .clk  (clk),
            .en   (en),
            .ax   (i_x[k]),
            .ay   (i_y[k]),
            .bx   (o_x[k]),
            .by   (o_y[k]),
            .len2 (l_io[k])
        );

        scc_len u_len_oc (
            .clk  (clk),
            .en   (en),
            .ax   (o_x[k]),
            .ay   (o_y[k]),
            .bx   (cx),
            .by   (cy),
            .len2 (l_oc[k])
        );

        // Stage 4: hold reference lengths, scale the near distance
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                l_ic4_reg[k] <= l_ic[k];
                l_io4_reg[k] <= l_io[k];
                s_oc4_reg[k] <= SCALED_W'(l_oc[k]) * SCALED_W'(RATIO_SQ);
            end
        end
    end

    // Stage 5: pick the reference length, compare, combine both segments
    logic meets_reg, meets_next;

    always_comb
    begin
        logic [NSEG-1:0] seg_ok;
        logic [NSEG-1:0] close;
        len_t            ref_len;
        for (int k = 0; k < NSEG; k++)
        begin
            seg_ok[k] = cross_in[k] || outer_in[k];
            ref_len   = cross_in[k] ? l_ic4_reg[k] : l_io4_reg[k];
            close[k]  = (ref_len != '0) && (s_oc4_reg[k] <= SCALED_W'(ref_len));
        end
        meets_next = (&seg_ok) && (|close);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meets_reg <= meets_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8*OUT_BYTES-1){1'b0}}, meets_reg};

    // An accepted item enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted item missing from first stage");

    // A stall freezes every stage valid bit and the result
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(valid_reg) && $stable(meets_reg)))
        else $error("pipeline moved during a stall");

    // A bubble in the last stage never becomes a result
    a_bubble_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !valid_reg[NSTAGE-1]) |=> !m_tvalid)
        else $error("result shown for an empty stage");

    // A result appears only after a valid last stage advanced
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(valid_reg[NSTAGE-1] && en))
        else $error("result without a source item");

endmodule

// ----- hw/rtl/scc_contain.sv -----
// Four-stage test of whether point P lies on segment A..B within a tolerance.
`timescale 1ns / 1ps

module scc_contain
    import scc_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  tol_t   tol,
    input  coord_t px,
    input  coord_t py,
    input  coord_t ax,
    input  coord_t ay,
    input  coord_t bx,
    input  coord_t by,
    output logic   on_seg
);

    // Stage 1: differences, magnitudes and axis-aligned flags
    diff_t dx_reg, dy_reg, ex_reg, ey_reg, exn_reg;
    diff_t dx_next, dy_next, ex_next, ey_next, exn_next;
    mag_t  dxa_reg, absx_reg, absy_reg;
    mag_t  dxa_next, absx_next, absy_next;
    logic  vert1_reg, horiz1_reg, in_vy_reg, in_hx_reg;
    logic  vert1_next, horiz1_next, in_vy_next, in_hx_next;

    always_comb
    begin
        diff_t neg_dx;
        diff_t neg_ex;
        diff_t neg_ey;
        dx_next     = DIFF_W'(bx) - DIFF_W'(ax);
        dy_next     = DIFF_W'(by) - DIFF_W'(ay);
        ex_next     = DIFF_W'(px) - DIFF_W'(ax);
        ey_next     = DIFF_W'(py) - DIFF_W'(ay);
        neg_dx      = DIFF_W'(ax) - DIFF_W'(bx);
        neg_ex      = DIFF_W'(ax) - DIFF_W'(px);
        neg_ey      = DIFF_W'(ay) - DIFF_W'(py);
        // fold the sign of dx into dx and ex
        dxa_next    = (bx < ax) ? neg_dx[MAG_W-1:0] : dx_next[MAG_W-1:0];
        exn_next    = (bx < ax) ? neg_ex : ex_next;
        absx_next   = (px < ax) ? neg_ex[MAG_W-1:0] : ex_next[MAG_W-1:0];
        absy_next   = (py < ay) ? neg_ey[MAG_W-1:0] : ey_next[MAG_W-1:0];
        vert1_next  = (ax == bx);
        horiz1_next = (ay == by);
        in_vy_next  = ((ay <= py) && (py <= by)) || ((by <= py) && (py <= ay));
        in_hx_next  = ((ax <= px) && (px <= bx)) || ((bx <= px) && (px <= ax));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            ex_reg     <= ex_next;
            ey_reg     <= ey_next;
            exn_reg    <= exn_next;
            dxa_reg    <= dxa_next;
            absx_reg   <= absx_next;
            absy_reg   <= absy_next;
            vert1_reg  <= vert1_next;
            horiz1_reg <= horiz1_next;
            in_vy_reg  <= in_vy_next;
            in_hx_reg  <= in_hx_next;
        end
    end

    // Stage 2: products and the simple range tests
    prod_t  p1_reg, p2_reg, p1_next, p2_next;
    tprod_t tp2_reg, tp2_next;
    logic   vert2_reg, horiz2_reg, vert_ok2_reg, horiz_ok2_reg, ex_ok2_reg;
    logic   vert_ok2_next, horiz_ok2_next, ex_ok2_next;

    always_comb
    begin
        logic signed [2*DIFF_W-1:0] m1;
        logic signed [2*DIFF_W-1:0] m2;
        m1             = ey_reg * dx_reg;
        m2             = ex_reg * dy_reg;
        p1_next        = m1[PROD_W-1:0];
        p2_next        = m2[PROD_W-1:0];
        tp2_next       = TPROD_W'(tol) * TPROD_W'(dxa_reg);
        vert_ok2_next  = in_vy_reg && (absx_reg < MAG_W'(tol));
        horiz_ok2_next = in_hx_reg && (absy_reg < MAG_W'(tol));
        ex_ok2_next    = !exn_reg[DIFF_W-1] && (exn_reg[MAG_W-1:0] <= dxa_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            tp2_reg       <= tp2_next;
            vert2_reg     <= vert1_reg;
            horiz2_reg    <= horiz1_reg;
            vert_ok2_reg  <= vert_ok2_next;
            horiz_ok2_reg <= horiz_ok2_next;
            ex_ok2_reg    <= ex_ok2_next;
        end
    end

    // Stage 3: cross product
    cross_t cross_reg, cross_next;
    tprod_t tp3_reg;
    logic   vert3_reg, horiz3_reg, vert_ok3_reg, horiz_ok3_reg, ex_ok3_reg;

    assign cross_next = CROSS_W'(p1_reg) - CROSS_W'(p2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cross_reg     <= cross_next;
            tp3_reg       <= tp2_reg;
            vert3_reg     <= vert2_reg;
            horiz3_reg    <= horiz2_reg;
            vert_ok3_reg  <= vert_ok2_reg;
            horiz_ok3_reg <= horiz_ok2_reg;
            ex_ok3_reg    <= ex_ok2_reg;
        end
    end

    // Stage 4: error bound and case selection
    logic on_seg_reg, on_seg_next;

    always_comb
    begin
        cross_t tp_s;
        logic   err_ok;
        tp_s   = $signed({{(CROSS_W-TPROD_W){1'b0}}, tp3_reg});
        err_ok = (cross_reg < tp_s) && (cross_reg > -tp_s);
        if (vert3_reg)
            on_seg_next = vert_ok3_reg;
        else if (horiz3_reg)
            on_seg_next = horiz_ok3_reg;
        else
            on_seg_next = ex_ok3_reg && err_ok;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            on_seg_reg <= on_seg_next;
        end
    end

    assign on_seg = on_seg_reg;

endmodule

// ----- hw/rtl/scc_len.sv -----
// Three-stage squared distance between two points.
`timescale 1ns / 1ps

module scc_len
    import scc_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  coord_t ax,
    input  coord_t ay,
    input  coord_t bx,
    input  coord_t by,
    output len_t   len2
);

    // Stage 1: differences
    diff_t dx_reg, dy_reg, dx_next, dy_next;

    assign dx_next = DIFF_W'(ax) - DIFF_W'(bx);
    assign dy_next = DIFF_W'(ay) - DIFF_W'(by);

    // Stage 2: squares
    sq_t sqx_reg, sqy_reg, sqx_next, sqy_next;

    always_comb
    begin
        logic signed [2*DIFF_W-1:0] mx;
        logic signed [2*DIFF_W-1:0] my;
        mx       = dx_reg * dx_reg;
        my       = dy_reg * dy_reg;
        sqx_next = mx[SQ_W-1:0];
        sqy_next = my[SQ_W-1:0];
    end

    // Stage 3: sum
    len_t sum_reg, sum_next;

    assign sum_next = LEN_W'(sqx_reg) + LEN_W'(sqy_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            sum_reg <= sum_next;
        end
    end

    assign len2 = sum_reg;

endmodule
